[rtl/mvsm_pkg.sv]
// ----------------------------------------------------------------------------
// Multi-voice sample mixer package
// Shared widths, codes and types of the stereo sample-playback mixer.
// ----------------------------------------------------------------------------
package mvsm_pkg;

   // Default sizes of the voice table and the wave memory.
   localparam int VOICE_COUNT_DEF = 64;
   localparam int WAVE_FRAMES_DEF = 65536;

   // Field widths of a request and a response.
   localparam int KIND_W   = 2;
   localparam int VOICE_W  = 6;
   localparam int ADDR_W   = 16;
   localparam int LEN_W    = 17;
   localparam int SAMPLE_W = 16;

   // Width of base plus position before it wraps into the wave memory.
   localparam int SUM_W = 18;

   // Saturation limits of a mixed sample.
   localparam int SAMPLE_MAX = 32767;
   localparam int SAMPLE_MIN = -32768;

   // Request kinds.
   typedef enum logic [KIND_W-1:0] {
      KIND_LOAD    = 2'd0,
      KIND_DEFINE  = 2'd1,
      KIND_TRIGGER = 2'd2,
      KIND_OUTPUT  = 2'd3
   } kind_type;

   // One entry of the voice memory.
   typedef struct packed {
      logic              active;
      logic [LEN_W-1:0]  pos;
      logic [LEN_W-1:0]  len;
      logic [ADDR_W-1:0] base;
   } voice_entry_type;

   // Control that travels with an address through the wrap pipeline.
   typedef struct packed {
      logic valid;
      logic load;
      logic hit;
      logic last;
   } wrap_tag_type;

endpackage

[rtl/mvsm_ram.sv]
// ----------------------------------------------------------------------------
// Mixer generic RAM
// Simple dual-port memory: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module mvsm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port, registered.
   always_ff @(posedge clock) begin
      rd_data <= mem_ff[rd_addr];
   end

endmodule

[rtl/mvsm_wrap.sv]
// ----------------------------------------------------------------------------
// Mixer address wrap
// Two-stage pipeline that reduces a frame address modulo the wave memory
// depth by restoring subtraction of shifted copies of the depth.
// ----------------------------------------------------------------------------
module mvsm_wrap import mvsm_pkg::*; #(
   parameter int WAVE_FRAMES = WAVE_FRAMES_DEF,
   localparam int WA_W       = $clog2(WAVE_FRAMES)
) (
   input  logic             clock,
   input  logic             reset,
   input  wrap_tag_type     in_tag,
   input  logic [SUM_W-1:0] in_sum,
   output wrap_tag_type     out_tag,
   output logic [WA_W-1:0]  out_addr
);

   // Number of subtract steps so that any SUM_W-bit value ends below the depth.
   localparam int STEPS = (WAVE_FRAMES >= (2 ** SUM_W)) ? 0 :
                          $clog2(((2 ** SUM_W) + WAVE_FRAMES - 1) / WAVE_FRAMES);
   localparam int HALF  = STEPS / 2;

   wrap_tag_type     a_tag_ff;
   logic [SUM_W-1:0] a_val_ff;
   logic [SUM_W-1:0] a_val_in;
   wrap_tag_type     b_tag_ff;
   logic [SUM_W-1:0] b_val_ff;
   logic [SUM_W-1:0] b_val_in;

   // First stage: the upper half of the subtract steps.
   always_comb begin
      logic [SUM_W-1:0] v;
      v = in_sum;
      for (int k = STEPS - 1; k >= HALF; k--) begin
         if (v >= SUM_W'(WAVE_FRAMES << k)) begin
            v = v - SUM_W'(WAVE_FRAMES << k);
         end
      end
      a_val_in = v;
   end

   // Second stage: the lower half of the subtract steps.
   always_comb begin
      logic [SUM_W-1:0] v;
      v = a_val_ff;
      for (int k = HALF - 1; k >= 0; k--) begin
         if (v >= SUM_W'(WAVE_FRAMES << k)) begin
            v = v - SUM_W'(WAVE_FRAMES << k);
         end
      end
      b_val_in = v;
   end

   // Pipeline registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_tag_ff <= '0;
         b_tag_ff <= '0;
      end else begin
         a_tag_ff <= in_tag;
         b_tag_ff <= a_tag_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_val_ff <= a_val_in;
      b_val_ff <= b_val_in;
   end

   assign out_tag  = b_tag_ff;
   assign out_addr = WA_W'(b_val_ff);

endmodule

[rtl/multi_voice_sample_mixer.sv]
// ----------------------------------------------------------------------------
// Multi-voice sample mixer
// Stereo sample-playback mixer: requests load wave frames, define and
// trigger voices, or ask for one mixed output frame.
//
//   Channel  Direction  Ports                                   Moves
//   req      in         req_valid/req_ready, kind..load_right   one request
//   rsp      out        rsp_valid/rsp_ready, mix_left/right     one mixed frame
//
// Load steps through the load and wait states, define and trigger through a
// voice read and a voice write, and an output frame walks the voice memory
// read port one voice a cycle. After reset a clearing pass zeroes every voice
// entry while req_ready stays low.
// A finished frame waits in the response register; the next request is taken
// meanwhile, and only a second finished frame waits for rsp_ready.
// ----------------------------------------------------------------------------
module multi_voice_sample_mixer import mvsm_pkg::*; #(
   parameter int VOICE_COUNT = VOICE_COUNT_DEF,
   parameter int WAVE_FRAMES = WAVE_FRAMES_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [KIND_W-1:0]          req_kind,
   input  logic [VOICE_W-1:0]         req_voice,
   input  logic [ADDR_W-1:0]          req_address,
   input  logic [LEN_W-1:0]           req_length,
   input  logic signed [SAMPLE_W-1:0] req_load_left,
   input  logic signed [SAMPLE_W-1:0] req_load_right,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [SAMPLE_W-1:0] rsp_mix_left,
   output logic signed [SAMPLE_W-1:0] rsp_mix_right
);

   localparam int VI_W  = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
   localparam int WA_W  = $clog2(WAVE_FRAMES);
   localparam int VE_W  = $bits(voice_entry_type);
   localparam int ACC_W = SAMPLE_W + $clog2(VOICE_COUNT) + 1;

   localparam logic signed [ACC_W-1:0] MIX_MAX = ACC_W'(SAMPLE_MAX);
   localparam logic signed [ACC_W-1:0] MIX_MIN = ACC_W'(SAMPLE_MIN);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_VREAD,
      ST_VWRITE,
      ST_LOAD,
      ST_LWAIT,
      ST_MIX,
      ST_DRAIN
   } state_type;

   // Control registers.
   state_type         state_ff, state_in;
   logic [VI_W-1:0]   walk_idx_ff, walk_idx_in;
   logic              s1_vld_ff, s1_vld_in;
   logic              rd_vld_ff, rd_vld_in;
   logic              done_ff, done_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_load;

   // Request and pipeline payload registers.
   kind_type                   kind_ff;
   logic [VOICE_W-1:0]         voice_ff;
   logic [ADDR_W-1:0]          addr_ff;
   logic [LEN_W-1:0]           length_ff;
   logic [SAMPLE_W-1:0]        left_ff;
   logic [SAMPLE_W-1:0]        right_ff;
   logic [VI_W-1:0]            s1_idx_ff;
   logic                       s1_last_ff;
   logic                       rd_hit_ff;
   logic                       rd_last_ff;
   logic signed [ACC_W-1:0]    acc_l_ff, acc_l_in;
   logic signed [ACC_W-1:0]    acc_r_ff, acc_r_in;
   logic signed [SAMPLE_W-1:0] rsp_left_ff;
   logic signed [SAMPLE_W-1:0] rsp_right_ff;

   // Memory ports and datapath.
   logic              accept;
   logic              voice_ok;
   logic              vr_wr_en;
   logic [VI_W-1:0]   vr_wr_addr;
   voice_entry_type   vr_wr_data;
   logic [VI_W-1:0]   vr_rd_addr;
   logic [VE_W-1:0]   vr_rd_data;
   voice_entry_type   cur;
   voice_entry_type   upd;
   voice_entry_type   mod;
   logic              cur_hit;
   logic [LEN_W-1:0]  pos_next;
   wrap_tag_type      wrap_in_tag;
   logic [SUM_W-1:0]  wrap_in_sum;
   wrap_tag_type      wrap_tag;
   logic [WA_W-1:0]   wrap_addr;
   logic              wave_we;
   logic [2*SAMPLE_W-1:0] wave_rd;

   // Halve by a floor shift and saturate to a 16-bit sample.
   function automatic logic signed [SAMPLE_W-1:0] half_sat(input logic signed [ACC_W-1:0] s);
      logic signed [ACC_W-1:0] h;
      h = s >>> 1;
      if (h > MIX_MAX) begin
         h = MIX_MAX;
      end else if (h < MIX_MIN) begin
         h = MIX_MIN;
      end
      return SAMPLE_W'(h);
   endfunction

   assign accept   = req_valid && req_ready;
   assign voice_ok = 32'(req_voice) < 32'(VOICE_COUNT);

   // Voice memory: base, length, position and active bit of each voice.
   mvsm_ram #(
      .WIDTH (VE_W),
      .DEPTH (VOICE_COUNT)
   ) u_voice_ram (
      .clock   (clock),
      .wr_en   (vr_wr_en),
      .wr_addr (vr_wr_addr),
      .wr_data (vr_wr_data),
      .rd_addr (vr_rd_addr),
      .rd_data (vr_rd_data)
   );

   // Read-modify-write of one voice entry during a walk or a define/trigger.
   always_comb begin
      cur      = voice_entry_type'(vr_rd_data);
      cur_hit  = cur.active && (cur.pos < cur.len);
      pos_next = cur.pos + LEN_W'(1);
      upd      = cur;
      if (cur.active) begin
         upd.pos    = pos_next;
         upd.active = pos_next < cur.len;
      end
      mod = cur;
      if (kind_ff == KIND_DEFINE) begin
         mod.base = addr_ff;
         mod.len  = length_ff;
      end else begin
         mod.pos    = '0;
         mod.active = 1'b1;
      end
   end

   // Voice memory port selection.
   always_comb begin
      vr_rd_addr = (state_ff == ST_VREAD) ? VI_W'(voice_ff) : walk_idx_ff;
      vr_wr_en   = 1'b0;
      vr_wr_addr = walk_idx_ff;
      vr_wr_data = '0;
      if (state_ff == ST_CLEAR) begin
         vr_wr_en = 1'b1;
      end else if (state_ff == ST_VWRITE) begin
         vr_wr_en   = 1'b1;
         vr_wr_addr = VI_W'(voice_ff);
         vr_wr_data = mod;
      end else if (s1_vld_ff) begin
         vr_wr_en   = 1'b1;
         vr_wr_addr = s1_idx_ff;
         vr_wr_data = upd;
      end
   end

   // Address wrap input: a voice's base plus position, or a load address.
   always_comb begin
      wrap_in_tag.valid = s1_vld_ff || (state_ff == ST_LOAD);
      wrap_in_tag.load  = !s1_vld_ff;
      wrap_in_tag.hit   = s1_vld_ff && cur_hit;
      wrap_in_tag.last  = s1_vld_ff && s1_last_ff;
      wrap_in_sum       = s1_vld_ff ? (SUM_W'(cur.base) + SUM_W'(cur.pos)) : SUM_W'(addr_ff);
   end

   mvsm_wrap #(
      .WAVE_FRAMES (WAVE_FRAMES)
   ) u_wrap (
      .clock    (clock),
      .reset    (reset),
      .in_tag   (wrap_in_tag),
      .in_sum   (wrap_in_sum),
      .out_tag  (wrap_tag),
      .out_addr (wrap_addr)
   );

   // Wave memory: left sample in the low half, right in the high half.
   assign wave_we = wrap_tag.valid && wrap_tag.load;

   mvsm_ram #(
      .WIDTH (2 * SAMPLE_W),
      .DEPTH (WAVE_FRAMES)
   ) u_wave_ram (
      .clock   (clock),
      .wr_en   (wave_we),
      .wr_addr (wrap_addr),
      .wr_data ({right_ff, left_ff}),
      .rd_addr (wrap_addr),
      .rd_data (wave_rd)
   );

   // Sequencer next state and accumulation.
   always_comb begin
      state_in    = state_ff;
      walk_idx_in = walk_idx_ff;
      s1_vld_in   = 1'b0;
      rd_vld_in   = wrap_tag.valid && !wrap_tag.load;
      done_in     = done_ff;
      rsp_load    = 1'b0;
      acc_l_in    = acc_l_ff;
      acc_r_in    = acc_r_ff;

      case (state_ff)
         ST_CLEAR: begin
            walk_idx_in = walk_idx_ff + VI_W'(1);
            if (walk_idx_ff == VI_W'(VOICE_COUNT - 1)) begin
               walk_idx_in = '0;
               state_in    = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               case (kind_type'(req_kind))
                  KIND_LOAD:    state_in = ST_LOAD;
                  KIND_DEFINE:  state_in = voice_ok ? ST_VREAD : ST_IDLE;
                  KIND_TRIGGER: state_in = voice_ok ? ST_VREAD : ST_IDLE;
                  KIND_OUTPUT: begin
                     state_in = ST_MIX;
                     acc_l_in = '0;
                     acc_r_in = '0;
                  end
                  default:      state_in = ST_IDLE;
               endcase
            end
         end
         ST_VREAD:  state_in = ST_VWRITE;
         ST_VWRITE: state_in = ST_IDLE;
         ST_LOAD:   state_in = ST_LWAIT;
         ST_LWAIT: begin
            if (wave_we) begin
               state_in = ST_IDLE;
            end
         end
         ST_MIX: begin
            s1_vld_in   = 1'b1;
            walk_idx_in = walk_idx_ff + VI_W'(1);
            if (walk_idx_ff == VI_W'(VOICE_COUNT - 1)) begin
               walk_idx_in = '0;
               state_in    = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (done_ff && (!rsp_valid_ff || rsp_ready)) begin
               rsp_load = 1'b1;
               done_in  = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // Each voice frame that plays adds into the running sums.
      if (rd_vld_ff) begin
         if (rd_hit_ff) begin
            acc_l_in = acc_l_ff + ACC_W'(signed'(wave_rd[SAMPLE_W-1:0]));
            acc_r_in = acc_r_ff + ACC_W'(signed'(wave_rd[2*SAMPLE_W-1:SAMPLE_W]));
         end
         if (rd_last_ff) begin
            done_in = 1'b1;
         end
      end

      // Response register handshake.
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   // Sequencer state and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         walk_idx_ff  <= '0;
         s1_vld_ff    <= 1'b0;
         rd_vld_ff    <= 1'b0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         walk_idx_ff  <= walk_idx_in;
         s1_vld_ff    <= s1_vld_in;
         rd_vld_ff    <= rd_vld_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
         if (rsp_load) begin
            rsp_left_ff  <= half_sat(acc_l_ff);
            rsp_right_ff <= half_sat(acc_r_ff);
         end
      end
   end

   // Request capture and pipeline payload.
   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff   <= kind_type'(req_kind);
         voice_ff  <= req_voice;
         addr_ff   <= req_address;
         length_ff <= req_length;
         left_ff   <= req_load_left;
         right_ff  <= req_load_right;
      end
      s1_idx_ff  <= walk_idx_ff;
      s1_last_ff <= walk_idx_ff == VI_W'(VOICE_COUNT - 1);
      rd_hit_ff  <= wrap_tag.hit;
      rd_last_ff <= wrap_tag.last;
      acc_l_ff   <= acc_l_in;
      acc_r_ff   <= acc_r_in;
   end

   assign req_ready     = state_ff == ST_IDLE;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_mix_left  = rsp_left_ff;
   assign rsp_mix_right = rsp_right_ff;

   // A frame in the wave read stage belongs to a walk that blocks new requests.
   a_busy_during_mix: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> !req_ready)
      else $error("request taken while an output frame is still summing");

   // The sum completes only while the sequencer waits for it.
   a_done_in_drain: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (state_ff == ST_DRAIN))
      else $error("frame sum completed outside the drain state");

   // Voice writeback happens only during or right after the walk.
   a_writeback_in_walk: assert property (@(posedge clock) disable iff (reset)
      s1_vld_ff |-> ((state_ff == ST_MIX) || (state_ff == ST_DRAIN)))
      else $error("voice writeback outside an output frame");

   // Every walk starts from the first voice.
   a_walk_rewound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (walk_idx_ff == '0))
      else $error("voice walk index not rewound when idle");

endmodule
